/* sv/tlsce_pkg.sv */
// tlsce_pkg: shared types and constants of the certificate extractor
// beat structs, parse phase codes and protocol field values
// no dependencies
package tlsce_pkg;

    // one input beat: frame byte with its end-of-frame mark
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_beat;

    // one output beat: certificate byte with its last mark
    typedef struct packed {
        logic [7:0] cert_byte;
        logic       cert_last;
    } t_out_beat;

    // result of one accepted input beat
    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_emit;

    // parser status seen by the top level
    typedef struct packed {
        logic capture_pending;
    } t_parse_status;

    // parse phases
    localparam logic [3:0] PH_ETH     = 4'd0;
    localparam logic [3:0] PH_IP      = 4'd1;
    localparam logic [3:0] PH_TCP     = 4'd2;
    localparam logic [3:0] PH_REC     = 4'd3;
    localparam logic [3:0] PH_SKIP    = 4'd4;
    localparam logic [3:0] PH_REC2    = 4'd5;
    localparam logic [3:0] PH_CERTHDR = 4'd6;
    localparam logic [3:0] PH_CAPTURE = 4'd7;
    localparam logic [3:0] PH_IDLE    = 4'd8;

    // protocol constants
    localparam logic [15:0] ETH_LAST_IDX     = 16'd13;
    localparam logic [15:0] IP_PROTO_IDX     = 16'd9;
    localparam logic [7:0]  IP_PROTO_TCP     = 8'd6;
    localparam logic [5:0]  MIN_HDR_BYTES    = 6'd20;
    localparam logic [15:0] TCP_OFFSET_IDX   = 16'd12;
    localparam logic [7:0]  TLS_HANDSHAKE    = 8'd22;
    localparam logic [7:0]  HS_SERVER_HELLO  = 8'd2;
    localparam logic [7:0]  HS_CERTIFICATE   = 8'd11;
    localparam logic [15:0] REC_LEN_HI_IDX   = 16'd3;
    localparam logic [15:0] REC_LEN_LO_IDX   = 16'd4;
    localparam logic [15:0] REC_MSG_TYPE_IDX = 16'd5;
    localparam logic [15:0] CERT_LEN_END_IDX = 16'd3;
    localparam logic [15:0] CERT_HDR_END_IDX = 16'd6;
    localparam logic [15:0] SERVER_PORT_RST  = 16'd443;

endpackage

/* sv/tlsce_parser.sv */
// tlsce_parser: frame parse state and per-beat decision
// one accepted beat updates the state and may produce one certificate byte
// depends on tlsce_pkg
module tlsce_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  tlsce_pkg::t_in_beat     i_beat,
    input  logic [15:0]             i_server_port,
    output tlsce_pkg::t_emit        o_emit,
    output tlsce_pkg::t_parse_status o_status
);

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_skip, n_skip;
    logic        r_rej, n_rej;
    logic [5:0]  r_ihb, n_ihb;
    logic [5:0]  r_thb, n_thb;
    logic [7:0]  r_port_hi, n_port_hi;
    logic [15:0] r_rec, n_rec;
    logic [23:0] r_rem, n_rem;

    logic [7:0]  b;
    logic [16:0] s_inc;
    logic [5:0]  ihb_now;
    logic [5:0]  thb_now;
    logic [15:0] port_now;
    logic [23:0] rem_dec;

    assign b        = i_beat.frame_byte;
    assign s_inc    = {1'b0, r_skip} + 17'd1;
    assign ihb_now  = (r_skip == 16'd0) ? {b[3:0], 2'b00} : r_ihb;
    assign thb_now  = (r_skip == tlsce_pkg::TCP_OFFSET_IDX) ? {b[7:4], 2'b00} : r_thb;
    assign port_now = {r_port_hi, b};
    assign rem_dec  = r_rem - 24'd1;

    // next state for one accepted beat
    always_comb begin
        n_phase   = r_phase;
        n_skip    = (r_skip != 16'hFFFF) ? r_skip + 16'd1 : r_skip;
        n_rej     = r_rej;
        n_ihb     = r_ihb;
        n_thb     = r_thb;
        n_port_hi = r_port_hi;
        n_rec     = r_rec;
        n_rem     = r_rem;
        o_emit    = '0;

        if (!r_rej) begin
            case (r_phase)
                tlsce_pkg::PH_ETH: begin
                    if (r_skip == tlsce_pkg::ETH_LAST_IDX) begin
                        n_phase = tlsce_pkg::PH_IP;
                        n_skip  = '0;
                    end
                end
                tlsce_pkg::PH_IP: begin
                    if (r_skip == 16'd0) begin
                        n_ihb = ihb_now;
                        if (ihb_now < tlsce_pkg::MIN_HDR_BYTES) n_rej = 1'b1;
                    end else if (r_skip == tlsce_pkg::IP_PROTO_IDX &&
                                 b != tlsce_pkg::IP_PROTO_TCP) begin
                        n_rej = 1'b1;
                    end
                    if (!n_rej && s_inc == {11'd0, ihb_now}) begin
                        n_phase = tlsce_pkg::PH_TCP;
                        n_skip  = '0;
                    end
                end
                tlsce_pkg::PH_TCP: begin
                    if (r_skip == 16'd0) begin
                        n_port_hi = b;
                    end else if (r_skip == 16'd1) begin
                        if (port_now != i_server_port) n_rej = 1'b1;
                    end else if (r_skip == tlsce_pkg::TCP_OFFSET_IDX) begin
                        n_thb = thb_now;
                        if (thb_now < tlsce_pkg::MIN_HDR_BYTES) n_rej = 1'b1;
                    end
                    if (!n_rej && r_skip >= tlsce_pkg::TCP_OFFSET_IDX &&
                        s_inc == {11'd0, thb_now}) begin
                        n_phase = (r_rem != '0) ? tlsce_pkg::PH_CAPTURE : tlsce_pkg::PH_REC;
                        n_skip  = '0;
                    end
                end
                tlsce_pkg::PH_REC: begin
                    if (r_skip == 16'd0) begin
                        if (b != tlsce_pkg::TLS_HANDSHAKE) n_rej = 1'b1;
                    end else if (r_skip == tlsce_pkg::REC_LEN_HI_IDX) begin
                        n_rec = {b, 8'h00};
                    end else if (r_skip == tlsce_pkg::REC_LEN_LO_IDX) begin
                        n_rec = {r_rec[15:8], b};
                    end else if (r_skip == tlsce_pkg::REC_MSG_TYPE_IDX) begin
                        if (b == tlsce_pkg::HS_SERVER_HELLO) begin
                            // server hello record is skipped whole
                            if (r_rec == 16'd0) begin
                                n_rej = 1'b1;
                            end else if (r_rec == 16'd1) begin
                                n_phase = tlsce_pkg::PH_REC2;
                                n_skip  = '0;
                            end else begin
                                n_phase = tlsce_pkg::PH_SKIP;
                                n_skip  = 16'd1;
                            end
                        end else if (b == tlsce_pkg::HS_CERTIFICATE) begin
                            n_phase = tlsce_pkg::PH_CERTHDR;
                            n_skip  = 16'd1;
                        end else begin
                            n_phase = tlsce_pkg::PH_IDLE;
                        end
                    end
                end
                tlsce_pkg::PH_SKIP: begin
                    if (s_inc >= {1'b0, r_rec}) begin
                        n_phase = tlsce_pkg::PH_REC2;
                        n_skip  = '0;
                    end
                end
                tlsce_pkg::PH_REC2: begin
                    if (r_skip == 16'd0) begin
                        if (b != tlsce_pkg::TLS_HANDSHAKE) n_rej = 1'b1;
                    end else if (r_skip == tlsce_pkg::REC_MSG_TYPE_IDX) begin
                        if (b == tlsce_pkg::HS_CERTIFICATE) begin
                            n_phase = tlsce_pkg::PH_CERTHDR;
                            n_skip  = 16'd1;
                        end else begin
                            n_phase = tlsce_pkg::PH_IDLE;
                        end
                    end
                end
                tlsce_pkg::PH_CERTHDR: begin
                    // 24-bit certificate length, then skip to the data
                    if (r_skip inside {[16'd1:tlsce_pkg::CERT_LEN_END_IDX]}) begin
                        n_rem = {r_rem[15:0], b};
                    end else if (r_skip >= tlsce_pkg::CERT_HDR_END_IDX) begin
                        n_phase = (r_rem != '0) ? tlsce_pkg::PH_CAPTURE : tlsce_pkg::PH_IDLE;
                        n_skip  = '0;
                    end
                end
                tlsce_pkg::PH_CAPTURE: begin
                    if (r_rem != '0) begin
                        n_rem                 = rem_dec;
                        o_emit.valid          = 1'b1;
                        o_emit.beat.cert_byte = b;
                        o_emit.beat.cert_last = (rem_dec == '0);
                    end
                    if (n_rem == '0) n_phase = tlsce_pkg::PH_IDLE;
                end
                default: begin
                end
            endcase
        end

        // frame end drops the partial parse, a pending capture survives
        if (i_beat.frame_end) begin
            if (n_phase == tlsce_pkg::PH_CERTHDR) n_rem = '0;
            n_phase = tlsce_pkg::PH_ETH;
            n_skip  = '0;
            n_rej   = 1'b0;
        end

        if (!i_accept) o_emit.valid = 1'b0;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tlsce_pkg::PH_ETH;
            r_skip  <= '0;
            r_rej   <= 1'b0;
            r_rem   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_skip  <= n_skip;
            r_rej   <= n_rej;
            r_rem   <= n_rem;
        end
    end

    // header fields
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ihb     <= n_ihb;
            r_thb     <= n_thb;
            r_port_hi <= n_port_hi;
            r_rec     <= n_rec;
        end
    end

    assign o_status.capture_pending = (r_rem != '0);

endmodule

/* sv/tls_certificate_extractor.sv */
// tls_certificate_extractor: top level with config register and output register
// depends on tlsce_pkg and tlsce_parser
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one frame byte per
//   beat, frame_end set on the final byte of each Ethernet frame.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives extracted
//   certificate bytes; cert_last marks the byte that uses up the length.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the TCP
//   source port to inspect; it is always ready. Write only while idle.
//   Throughput: one input beat per cycle while the output is not stalled. Each
//   beat is parsed in the cycle it is accepted; its result, if any, is in the
//   output register on the next cycle.
//   Stall: while the output register holds an untaken beat and the receiver
//   is not ready, input is held off; when the receiver takes the beat the
//   next input beat is accepted in the same cycle.
//   Reset: synchronous, active low; parse restarts at the Ethernet header, no
//   capture pending, server port returns to 443, output register empty.
module tls_certificate_extractor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tlsce_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tlsce_pkg::t_out_beat o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data
);

    logic [15:0]              r_server_port;
    logic                     r_out_valid, n_out_valid;
    tlsce_pkg::t_out_beat     r_out_data;
    logic                     in_accept;
    tlsce_pkg::t_emit         emit;
    tlsce_pkg::t_parse_status status;

    // config register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_port <= tlsce_pkg::SERVER_PORT_RST;
        end else if (i_cfg_valid) begin
            r_server_port <= i_cfg_data;
        end
    end

    // input beat accepted when the output register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    tlsce_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_beat        (i_in_data),
        .i_server_port (r_server_port),
        .o_emit        (emit),
        .o_status      (status)
    );

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (emit.valid) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out_data <= emit.beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // a beat is emitted only from a pending capture
    a_emit_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.valid |-> status.capture_pending)
        else $error("certificate byte emitted with no capture pending");

    // the last beat ends the capture
    a_last_ends_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit.valid && emit.beat.cert_last) |=> !status.capture_pending)
        else $error("capture still pending after last certificate byte");

    // a non-last beat leaves the capture pending
    a_more_keeps_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit.valid && !emit.beat.cert_last) |=> status.capture_pending)
        else $error("capture ended before last certificate byte");

    // output valid rises only after an accepted input beat
    a_out_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_accept))
        else $error("output beat without an accepted input beat");
`endif

endmodule

/* tb/tb_tls_certificate_extractor.sv */
`timescale 1ns / 1ps
// tb_tls_certificate_extractor: self-checking bench for the certificate extractor
// sends framed ethernet byte streams, predicts extracted certificate bytes in a scoreboard
// depends on tlsce_pkg and tls_certificate_extractor
module tb_tls_certificate_extractor;
    import tlsce_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int RANDOM_BYTES = 400;
    localparam int ETH_BYTES    = 14;

    // values the block must treat as "something else"
    localparam logic [7:0] IP_PROTO_UDP    = 8'd17;
    localparam logic [7:0] REC_APP_DATA    = 8'd23;
    localparam logic [7:0] REC_ALERT       = 8'd21;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'd1;
    localparam logic [7:0] HS_HELLO_DONE   = 8'd14;

    // predicts extracted bytes and checks them in order
    class cert_scoreboard;
        logic [15:0] port;
        logic [3:0]  phase;
        logic [5:0]  ip_len;
        logic [5:0]  tcp_len;
        logic [15:0] port_acc;
        logic [15:0] rec_len;
        logic [15:0] sect_idx;
        logic [23:0] cert_left;
        logic        dropped;
        t_out_beat   waiting[$];
        int          errors;
        int          checked;

        function new();
            port      = SERVER_PORT_RST;
            cert_left = '0;
            errors    = 0;
            checked   = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase    = PH_ETH;
            ip_len   = '0;
            tcp_len  = '0;
            port_acc = '0;
            rec_len  = '0;
            sect_idx = '0;
            dropped  = 1'b0;
        endfunction

        function void write_port(logic [15:0] p);
            port = p;
        endfunction

        // parse one accepted frame byte, queue the certificate byte it yields
        function void note_frame_byte(t_in_beat beat);
            logic [7:0]  b;
            logic [15:0] s;
            logic [15:0] nxt;
            t_out_beat   res;
            b   = beat.frame_byte;
            s   = sect_idx;
            nxt = (s != 16'hFFFF) ? s + 16'd1 : s;
            if (!dropped) begin
                case (phase)
                    PH_ETH: begin
                        if (s == ETH_LAST_IDX) begin
                            phase = PH_IP;
                            nxt   = '0;
                        end
                    end
                    PH_IP: begin
                        if (s == 16'd0) begin
                            ip_len  = {b[3:0], 2'b00};
                            dropped = (ip_len < MIN_HDR_BYTES);
                        end else if (s == IP_PROTO_IDX && b != IP_PROTO_TCP) begin
                            dropped = 1'b1;
                        end
                        if (!dropped && s + 32'd1 == ip_len) begin
                            phase = PH_TCP;
                            nxt   = '0;
                        end
                    end
                    PH_TCP: begin
                        if (s == 16'd0) begin
                            port_acc = {b, 8'h00};
                        end else if (s == 16'd1) begin
                            port_acc = {port_acc[15:8], b};
                            if (port_acc != port) dropped = 1'b1;
                        end else if (s == TCP_OFFSET_IDX) begin
                            tcp_len = {b[7:4], 2'b00};
                            if (tcp_len < MIN_HDR_BYTES) dropped = 1'b1;
                        end
                        if (!dropped && s >= TCP_OFFSET_IDX && s + 32'd1 == tcp_len) begin
                            phase = (cert_left != 0) ? PH_CAPTURE : PH_REC;
                            nxt   = '0;
                        end
                    end
                    PH_REC: begin
                        if (s == 16'd0) begin
                            if (b != TLS_HANDSHAKE) dropped = 1'b1;
                        end else if (s == REC_LEN_HI_IDX) begin
                            rec_len = {b, 8'h00};
                        end else if (s == REC_LEN_LO_IDX) begin
                            rec_len = {rec_len[15:8], b};
                        end else if (s == REC_MSG_TYPE_IDX) begin
                            if (b == HS_SERVER_HELLO) begin
                                if (rec_len == 16'd0) begin
                                    dropped = 1'b1;
                                end else if (rec_len == 16'd1) begin
                                    phase = PH_REC2;
                                    nxt   = '0;
                                end else begin
                                    phase = PH_SKIP;
                                    nxt   = 16'd1;
                                end
                            end else if (b == HS_CERTIFICATE) begin
                                phase = PH_CERTHDR;
                                nxt   = 16'd1;
                            end else begin
                                phase = PH_IDLE;
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (s + 32'd1 >= rec_len) begin
                            phase = PH_REC2;
                            nxt   = '0;
                        end
                    end
                    PH_REC2: begin
                        if (s == 16'd0) begin
                            if (b != TLS_HANDSHAKE) dropped = 1'b1;
                        end else if (s == REC_MSG_TYPE_IDX) begin
                            if (b == HS_CERTIFICATE) begin
                                phase = PH_CERTHDR;
                                nxt   = 16'd1;
                            end else begin
                                phase = PH_IDLE;
                            end
                        end
                    end
                    PH_CERTHDR: begin
                        if (s >= 16'd1 && s <= CERT_LEN_END_IDX) begin
                            cert_left = {cert_left[15:0], b};
                        end else if (s >= CERT_HDR_END_IDX) begin
                            phase = (cert_left != 0) ? PH_CAPTURE : PH_IDLE;
                            nxt   = '0;
                        end
                    end
                    PH_CAPTURE: begin
                        if (cert_left != 0) begin
                            cert_left     = cert_left - 24'd1;
                            res.cert_byte = b;
                            res.cert_last = (cert_left == 0);
                            waiting.push_back(res);
                        end
                        if (cert_left == 0) phase = PH_IDLE;
                    end
                    default: ;
                endcase
            end
            sect_idx = nxt;

            // frame end drops the partial parse, a half-read certificate header too
            if (beat.frame_end) begin
                if (phase == PH_CERTHDR) cert_left = '0;
                clear_frame();
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        function void check_cert_byte(t_out_beat got);
            t_out_beat want;
            if (waiting.size() == 0) begin
                report($sformatf("byte %02h last %0b with nothing predicted",
                                 got.cert_byte, got.cert_last));
                return;
            end
            want = waiting.pop_front();
            checked++;
            if (got.cert_byte !== want.cert_byte || got.cert_last !== want.cert_last)
                report($sformatf("byte %0d expected %02h last %0b, got %02h last %0b",
                                 checked, want.cert_byte, want.cert_last,
                                 got.cert_byte, got.cert_last));
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_beat    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_beat   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    logic        calm      = 1'b0;
    logic [15:0] port_now  = SERVER_PORT_RST;
    logic [7:0]  frame_q[$];
    int          tcp_at;
    int          pay_at;
    int          frames_sent = 0;
    int          bytes_sent  = 0;
    cert_scoreboard sb;

    always #4 clk = ~clk;

    tls_certificate_extractor uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // beat monitor: frame bytes in, certificate bytes out, port writes
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.write_port(cfg_data);
            if (in_valid && in_ready) sb.note_frame_byte(in_data);
            if (out_valid && out_ready) sb.check_cert_byte(out_data);
        end
    end

    // receiver with random stalls
    initial begin : receiver
        int gap;
        forever begin
            gap = calm ? 0 : int'($urandom_range(0, 6));
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d bytes still predicted",
                 LIMIT_CYCLES, sb.waiting.size());
        $display("tb_tls_certificate_extractor: done, errors");
        $finish;
    end

    task automatic send_beat(logic [7:0] b, logic fin);
        int       gap;
        t_in_beat beat;
        gap             = calm ? 0 : int'($urandom_range(0, 6));
        beat.frame_byte = b;
        beat.frame_end  = fin;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_frame();
        calm = ($urandom_range(0, 3) == 0);
        foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
        bytes_sent += frame_q.size();
        frame_q.delete();
    endtask

    // hold input until every predicted byte is out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.waiting.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_port(logic [15:0] p);
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        port_now  = p;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic put_rand(int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    function automatic logic [3:0] rand_hlen();
        return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    endfunction

    // ethernet, ipv4 and tcp headers; short header lengths still get 20 bytes
    task automatic put_headers(logic [3:0] ihl, logic [7:0] proto, logic [15:0] port,
                               logic [3:0] doff);
        int ip_bytes;
        int tcp_bytes;
        ip_bytes  = (ihl < 5) ? 20 : ihl * 4;
        tcp_bytes = (doff < 5) ? 20 : doff * 4;
        put_rand(ETH_BYTES);
        frame_q.push_back({4'h4, ihl});
        for (int i = 1; i < ip_bytes; i++)
            frame_q.push_back((i == int'(IP_PROTO_IDX)) ? proto : 8'($urandom));
        tcp_at = frame_q.size();
        frame_q.push_back(port[15:8]);
        frame_q.push_back(port[7:0]);
        put_rand(10);
        frame_q.push_back({doff, 4'($urandom)});
        put_rand(tcp_bytes - 13);
        pay_at = frame_q.size();
    endtask

    task automatic put_record_hdr(logic [7:0] kind, logic [15:0] len);
        frame_q.push_back(kind);
        put_rand(2);
        frame_q.push_back(len[15:8]);
        frame_q.push_back(len[7:0]);
    endtask

    task automatic put_hello(logic [15:0] len);
        put_record_hdr(TLS_HANDSHAKE, len);
        frame_q.push_back(HS_SERVER_HELLO);
        if (len > 1) put_rand(len - 1);
    endtask

    task automatic put_cert_hdr(logic [23:0] clen);
        put_record_hdr(TLS_HANDSHAKE, 16'($urandom));
        frame_q.push_back(HS_CERTIFICATE);
        frame_q.push_back(clen[23:16]);
        frame_q.push_back(clen[15:8]);
        frame_q.push_back(clen[7:0]);
        put_rand(3);
    endtask

    // hello_len below zero: no server hello record
    task automatic cert_frame(logic [3:0] ihl, logic [3:0] doff, int hello_len,
                              logic [23:0] clen, int data_n);
        put_headers(ihl, IP_PROTO_TCP, port_now, doff);
        if (hello_len >= 0) put_hello(16'(hello_len));
        put_cert_hdr(clen);
        put_rand(data_n);
    endtask

    task automatic cont_frame(logic [3:0] ihl, logic [3:0] doff, int n);
        put_headers(ihl, IP_PROTO_TCP, port_now, doff);
        put_rand(n);
    endtask

    // corrupt one header field or cut the frame short
    task automatic mangle_frame();
        int idx;
        if ($urandom_range(0, 2) == 0) begin
            frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 1)];
        end else begin
            case ($urandom_range(0, 8))
                0:       idx = ETH_BYTES;
                1:       idx = ETH_BYTES + int'(IP_PROTO_IDX);
                2:       idx = tcp_at;
                3:       idx = tcp_at + 1;
                4:       idx = tcp_at + int'(TCP_OFFSET_IDX);
                5:       idx = pay_at;
                6:       idx = pay_at + int'(REC_LEN_HI_IDX);
                7:       idx = pay_at + int'(REC_LEN_LO_IDX);
                default: idx = pay_at + int'(REC_MSG_TYPE_IDX);
            endcase
            if (idx < frame_q.size()) frame_q[idx] = 8'($urandom);
        end
    endtask

    task automatic random_cert_frame();
        int          hello_len;
        int          r;
        logic [23:0] clen;
        r = $urandom_range(0, 19);
        if ($urandom_range(0, 1)) hello_len = -1;
        else if (r == 0)          hello_len = 0;
        else                      hello_len = $urandom_range(1, 40);
        if (r == 1)      clen = 24'd0;
        else if (r == 2) clen = 24'($urandom_range(81, 300));
        else             clen = 24'($urandom_range(1, 80));
        cert_frame(rand_hlen(), rand_hlen(), hello_len, clen,
                   $urandom_range(0, int'(clen) + 10));
    endtask

    // records the block should walk past without capturing
    task automatic other_record_frame();
        logic [7:0] msg;
        put_headers(rand_hlen(), IP_PROTO_TCP, port_now, rand_hlen());
        if ($urandom_range(0, 1)) put_hello(16'($urandom_range(1, 30)));
        put_record_hdr($urandom_range(0, 1) ? TLS_HANDSHAKE : 8'($urandom), 16'($urandom));
        msg = 8'($urandom);
        if (msg == HS_CERTIFICATE) msg = HS_CLIENT_HELLO;
        frame_q.push_back(msg);
        put_rand($urandom_range(0, 30));
    endtask

    task automatic directed_frames();
        // whole certificate in one frame
        cert_frame(4'd5, 4'd5, -1, 24'd10, 10);  send_frame();
        // one-byte server hello, trailing bytes after the certificate
        cert_frame(4'd5, 4'd5, 1, 24'd5, 9);     send_frame();
        // long server hello, certificate runs into the next frame
        cert_frame(4'd5, 4'd5, 20, 24'd30, 12);  send_frame();
        cont_frame(4'd5, 4'd5, 40);              send_frame();
        // largest ip and tcp headers
        cert_frame(4'd15, 4'd15, -1, 24'd3, 3);  send_frame();
        // short ip header, short tcp header
        cert_frame(4'd4, 4'd5, -1, 24'd4, 4);    send_frame();
        cert_frame(4'd0, 4'd5, -1, 24'd4, 4);    send_frame();
        cert_frame(4'd5, 4'd4, -1, 24'd4, 4);    send_frame();
        // not tcp, wrong source port
        put_headers(4'd5, IP_PROTO_UDP, port_now, 4'd5);
        put_cert_hdr(24'd4); put_rand(4);        send_frame();
        put_headers(4'd5, IP_PROTO_TCP, port_now + 16'd1, 4'd5);
        put_cert_hdr(24'd4); put_rand(4);        send_frame();
        // empty server hello record
        cert_frame(4'd5, 4'd5, 0, 24'd4, 4);     send_frame();
        // non-handshake record, other handshake message
        put_headers(4'd5, IP_PROTO_TCP, port_now, 4'd5);
        put_record_hdr(REC_APP_DATA, 16'd8); frame_q.push_back(HS_CERTIFICATE);
        put_rand(10);                            send_frame();
        put_headers(4'd5, IP_PROTO_TCP, port_now, 4'd5);
        put_record_hdr(TLS_HANDSHAKE, 16'd10); frame_q.push_back(HS_CLIENT_HELLO);
        put_rand(12);                            send_frame();
        // server hello followed by a non-handshake record, then by another message
        put_headers(4'd5, IP_PROTO_TCP, port_now, 4'd5);
        put_hello(16'd4); put_record_hdr(REC_ALERT, 16'd2); put_rand(6);
        send_frame();
        put_headers(4'd5, IP_PROTO_TCP, port_now, 4'd5);
        put_hello(16'd4); put_record_hdr(TLS_HANDSHAKE, 16'd2);
        frame_q.push_back(HS_HELLO_DONE); put_rand(6);
        send_frame();
        // zero certificate length
        cert_frame(4'd5, 4'd5, -1, 24'd0, 6);    send_frame();
        // frame cut right after the certificate length: nothing may stay pending
        put_headers(4'd5, IP_PROTO_TCP, port_now, 4'd5);
        put_cert_hdr(24'hFFFFFF);
        frame_q = frame_q[0:$-3];                send_frame();
        cert_frame(4'd5, 4'd5, -1, 24'd2, 2);    send_frame();
        // frame ends right after the certificate header: capture stays pending,
        // also across a frame from another port
        cert_frame(4'd5, 4'd5, -1, 24'd6, 0);    send_frame();
        cont_frame(4'd5, 4'd5, 2);               send_frame();
        put_headers(4'd5, IP_PROTO_TCP, port_now ^ 16'h8000, 4'd5);
        put_rand(10);                            send_frame();
        cont_frame(4'd5, 4'd5, 8);               send_frame();
        // cut inside the ip header, single byte frames
        put_rand(20);                            send_frame();
        frame_q.push_back(8'hFF);                send_frame();
        frame_q.push_back(8'h00);                send_frame();
    endtask

    task automatic random_phase(int target);
        int got;
        int pick;
        bit noise;
        got = 0;
        while (got < target) begin
            pick  = $urandom_range(0, 99);
            noise = 1'b0;
            if (sb.cert_left != 0 && sb.cert_left < 4096 && pick < 75) begin
                cont_frame(rand_hlen(), rand_hlen(), $urandom_range(1, 60));
            end else if (pick < 60) begin
                random_cert_frame();
            end else if (pick < 70) begin
                other_record_frame();
            end else if (pick < 92) begin
                random_cert_frame();
                mangle_frame();
            end else begin
                put_rand($urandom_range(1, 40));
                noise = 1'b1;
            end
            if (!noise) got += frame_q.size();
            // now and then let everything drain before the next frame
            if ($urandom_range(0, 24) == 0) wait_drained();
            send_frame();
        end
    endtask

    initial begin : stimulus
        logic [15:0] ports[4];
        sb    = new();
        ports = '{16'd0, 16'hFFFF, 16'($urandom), SERVER_PORT_RST};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_frames();
        foreach (ports[k]) begin
            wait_drained();
            write_port(ports[k]);
            random_phase(RANDOM_BYTES / 4);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("sent %0d frames (%0d bytes), checked %0d certificate bytes",
                 frames_sent, bytes_sent, sb.checked);
        $display("server port at 443, 0, 65535 and %0d; %0d mismatches",
                 ports[2], sb.errors);
        if (sb.errors == 0) begin
            $display("tb_tls_certificate_extractor: done, clean");
        end else begin
            $display("tb_tls_certificate_extractor: done, errors");
        end
        $finish;
    end

endmodule
